// ===== sv/tdfe_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// tdfe_pkg
// Widths, fixed-point constants, arctangent table and sideband records
// shared by the slope direction and tilt datapath.
// ---------------------------------------------------------------------------
package tdfe_pkg;

    localparam int XW        = 32;  // CORDIC x/y
    localparam int ZW        = 22;  // angle, pi/2^20 units
    localparam int QW        = 30;  // Q28 magnitudes
    localparam int NUMW      = 30;
    localparam int DW        = 30;
    localparam int REMW      = 31;
    localparam int QTW       = 29;
    localparam int SQW       = 57;
    localparam int DIV_STEPS = 29;
    localparam int SQ_STEPS  = 29;

    localparam logic signed [XW-1:0] GAIN     = 32'sd163008218;
    localparam logic [27:0]          GAIN_U   = 28'd163008218;
    localparam logic [26:0]          RECIP45  = 27'd95443718;
    localparam logic [QW-1:0]        QONE     = 30'h1000_0000;
    localparam logic [QTW-1:0]       QONE_Z   = 29'h1000_0000;
    localparam logic signed [ZW-1:0] QUARTER  = 22'sd524288;
    localparam logic [SQW-1:0]       SQ_TOP   = 57'h100_0000_0000_0000;

    typedef struct packed {
        logic p_le0;
        logic r_le0;
    } quad_t;

    typedef struct packed {
        logic zero;
        logic quart;
    } ang_flags_t;

    typedef struct packed {
        quad_t      quad;
        ang_flags_t flags;
    } rot_side_t;

    typedef struct packed {
        quad_t             quad;
        logic [QW-1:0]     a;
        logic [QW-1:0]     b;
        logic [NUMW-1:0]   num;
    } v1_side_t;

    typedef struct packed {
        quad_t                 quad;
        logic                  deg;
        logic                  ovf;
        logic signed [ZW-1:0]  ang;
    } div_side_t;

    typedef struct packed {
        quad_t                 quad;
        logic                  deg;
        logic signed [ZW-1:0]  ang;
        logic [QTW-1:0]        zq;
    } sq_side_t;

    typedef struct packed {
        quad_t                 quad;
        logic                  deg;
        logic signed [ZW-1:0]  ang;
        logic                  y0;
        logic                  x0;
    } v2_side_t;

    function automatic logic signed [ZW-1:0] atan_at(input int i);
        case (i)
            0:       return 22'sd262144;
            1:       return 22'sd154753;
            2:       return 22'sd81767;
            3:       return 22'sd41506;
            4:       return 22'sd20834;
            5:       return 22'sd10427;
            6:       return 22'sd5215;
            7:       return 22'sd2608;
            8:       return 22'sd1304;
            9:       return 22'sd652;
            10:      return 22'sd326;
            11:      return 22'sd163;
            12:      return 22'sd81;
            13:      return 22'sd41;
            14:      return 22'sd20;
            15:      return 22'sd10;
            16:      return 22'sd5;
            17:      return 22'sd3;
            18:      return 22'sd1;
            19:      return 22'sd1;
            default: return 22'sd0;
        endcase
    endfunction

endpackage
`default_nettype wire

// ===== sv/tdfe_cordic_cell.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// tdfe_cordic_cell
// One CORDIC micro-rotation stage, rotation or vectoring mode, with valid
// and a sideband word carried alongside.
// ---------------------------------------------------------------------------
module tdfe_cordic_cell #(
    parameter bit VECTOR = 1'b0,
    parameter int STAGE  = 0,
    parameter int SIDE_W = 1
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            en,
    input  wire logic                            vld_in,
    input  wire logic signed [tdfe_pkg::XW-1:0]  x_in,
    input  wire logic signed [tdfe_pkg::XW-1:0]  y_in,
    input  wire logic signed [tdfe_pkg::ZW-1:0]  z_in,
    input  wire logic [SIDE_W-1:0]               side_in,
    output logic                                 vld_out,
    output logic signed [tdfe_pkg::XW-1:0]       x_out,
    output logic signed [tdfe_pkg::XW-1:0]       y_out,
    output logic signed [tdfe_pkg::ZW-1:0]       z_out,
    output logic [SIDE_W-1:0]                    side_out
);
    import tdfe_pkg::*;

    localparam logic signed [ZW-1:0] ANG = atan_at(STAGE);

    logic                 vld_reg;
    logic signed [XW-1:0] x_reg, y_reg, x_next, y_next, xs, ys;
    logic signed [ZW-1:0] z_reg, z_next;
    logic [SIDE_W-1:0]    side_reg;
    logic                 up;

    always_comb
    begin
        xs = x_in >>> STAGE;
        ys = y_in >>> STAGE;
        up = VECTOR ? y_in[XW-1] : !z_in[ZW-1];
        if (up)
        begin
            x_next = x_in - ys;
            y_next = y_in + xs;
            z_next = z_in - ANG;
        end
        else
        begin
            x_next = x_in + ys;
            y_next = y_in - xs;
            z_next = z_in + ANG;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= vld_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            side_reg <= side_in;
        end
    end

    assign vld_out  = vld_reg;
    assign x_out    = x_reg;
    assign y_out    = y_reg;
    assign z_out    = z_reg;
    assign side_out = side_reg;

endmodule
`default_nettype wire

// ===== sv/tdfe_div_cell.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// tdfe_div_cell
// One restoring-division step: compare, subtract, shift, one quotient bit.
// ---------------------------------------------------------------------------
module tdfe_div_cell #(
    parameter int SIDE_W = 1
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire logic                          vld_in,
    input  wire logic [tdfe_pkg::REMW-1:0]     rem_in,
    input  wire logic [tdfe_pkg::DW-1:0]       den_in,
    input  wire logic [tdfe_pkg::QTW-1:0]      q_in,
    input  wire logic [SIDE_W-1:0]             side_in,
    output logic                               vld_out,
    output logic [tdfe_pkg::REMW-1:0]          rem_out,
    output logic [tdfe_pkg::DW-1:0]            den_out,
    output logic [tdfe_pkg::QTW-1:0]           q_out,
    output logic [SIDE_W-1:0]                  side_out
);
    import tdfe_pkg::*;

    logic              vld_reg;
    logic [REMW-1:0]   rem_reg, rem_next, diff, t;
    logic [DW-1:0]     den_reg;
    logic [QTW-1:0]    q_reg, q_next;
    logic [SIDE_W-1:0] side_reg;
    logic              ge;

    always_comb
    begin
        ge       = rem_in >= {1'b0, den_in};
        diff     = rem_in - {1'b0, den_in};
        t        = ge ? diff : rem_in;
        rem_next = {t[REMW-2:0], 1'b0};
        q_next   = {q_in[QTW-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= vld_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            den_reg  <= den_in;
            q_reg    <= q_next;
            side_reg <= side_in;
        end
    end

    assign vld_out  = vld_reg;
    assign rem_out  = rem_reg;
    assign den_out  = den_reg;
    assign q_out    = q_reg;
    assign side_out = side_reg;

endmodule
`default_nettype wire

// ===== sv/tdfe_sqrt_cell.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// tdfe_sqrt_cell
// One digit step of the integer square root (binary restoring method).
// ---------------------------------------------------------------------------
module tdfe_sqrt_cell #(
    parameter int STEP   = 0,
    parameter int SIDE_W = 1
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        en,
    input  wire logic                        vld_in,
    input  wire logic [tdfe_pkg::SQW-1:0]    v_in,
    input  wire logic [tdfe_pkg::SQW-1:0]    r_in,
    input  wire logic [SIDE_W-1:0]           side_in,
    output logic                             vld_out,
    output logic [tdfe_pkg::SQW-1:0]         v_out,
    output logic [tdfe_pkg::SQW-1:0]         r_out,
    output logic [SIDE_W-1:0]                side_out
);
    import tdfe_pkg::*;

    localparam logic [SQW-1:0] BIT = SQW'(1) << (2 * (SQ_STEPS - 1 - STEP));

    logic              vld_reg;
    logic [SQW-1:0]    v_reg, r_reg, v_next, r_next, s;
    logic [SIDE_W-1:0] side_reg;
    logic              ge;

    always_comb
    begin
        s  = r_in + BIT;
        ge = v_in >= s;
        if (ge)
        begin
            v_next = v_in - s;
            r_next = (r_in >> 1) + BIT;
        end
        else
        begin
            v_next = v_in;
            r_next = r_in >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= vld_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_reg    <= v_next;
            r_reg    <= r_next;
            side_reg <= side_in;
        end
    end

    assign vld_out  = vld_reg;
    assign v_out    = v_reg;
    assign r_out    = r_reg;
    assign side_out = side_reg;

endmodule
`default_nettype wire

// ===== sv/tilt_direction_from_euler.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// tilt_direction_from_euler
// Slope direction and inclination from pitch and roll, fully pipelined.
// ---------------------------------------------------------------------------
// Input beat: pitch_deg, roll_deg (1/64 degree) on in_valid / in_stall.
// Output beat: slope_direction, slope_tilt, degenerate on out_valid /
// out_stall, one output beat per input beat, in order.
// Throughput: one beat per cycle unless stalled; every step is its own
// pipeline cell (sin/cos CORDIC, vectoring CORDIC, 29-step divider,
// 29-step square root, second vectoring CORDIC), so no unit is shared
// between beats.
// Stall: the whole pipe advances when the output register is empty or
// being taken; while out_valid is held with out_stall high, the pipe
// freezes and in_stall is raised. Bubbles never block accepted beats.
// Reset: clears every valid bit; no beats are in flight afterwards.
// ---------------------------------------------------------------------------
module tilt_direction_from_euler #(
    parameter int CORDIC_STAGES = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic signed [14:0] pitch_deg,
    input  wire logic signed [14:0] roll_deg,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [15:0]      slope_direction,
    output logic [13:0]             slope_tilt,
    output logic                    degenerate
);
    import tdfe_pkg::*;

    localparam int N     = CORDIC_STAGES;
    localparam int RSW   = $bits(rot_side_t);
    localparam int AFW   = $bits(ang_flags_t);
    localparam int V1W   = $bits(v1_side_t);
    localparam int DVW   = $bits(div_side_t);
    localparam int SQSW  = $bits(sq_side_t);
    localparam int V2W   = $bits(v2_side_t);

    function automatic logic [20:0] deg_to_ang(input logic signed [14:0] q);
        logic signed [15:0] qe;
        logic [15:0]        mag;
        logic [26:0]        m;
        logic [53:0]        prod;
        qe   = 16'(q);
        mag  = qe[15] ? 16'(-qe) : 16'(qe);
        m    = {mag[14:0], 12'b0} + 27'd22;
        prod = m * RECIP45;
        return prod[52:32];
    endfunction

    function automatic logic signed [ZW-1:0] fold_ang(input logic [20:0] mag,
                                                     input logic neg);
        logic signed [22:0] a;
        a = signed'({2'b00, mag});
        if (neg)
            a = -a;
        if (a > 23'sd1048576)
            a = a - 23'sd2097152;
        if (a < -23'sd1048576)
            a = a + 23'sd2097152;
        if (a > 23'sd524288)
            a = a - 23'sd1048576;
        if (a < -23'sd524288)
            a = a + 23'sd1048576;
        return a[ZW-1:0];
    endfunction

    function automatic logic [QW-1:0] mag_of(input logic signed [XW-1:0] v);
        logic signed [XW-1:0] t;
        t = v[XW-1] ? -v : v;
        return t[QW-1:0];
    endfunction

    function automatic logic [13:0] to_out(input logic signed [ZW-1:0] a);
        logic signed [ZW-1:0] t;
        logic [ZW-1:0]        r;
        t = a[ZW-1] ? '0 : a;
        r = (ZW'(t) + ZW'(32)) >> 6;
        return (r > ZW'(8192)) ? 14'd8192 : r[13:0];
    endfunction

    logic adv;

    // stage A: degree to angle units
    logic        a_vld_reg, a_pneg_reg, a_rneg_reg;
    logic [20:0] a_pmag_reg, a_rmag_reg;
    quad_t       a_quad_reg, a_quad_next;

    // stage B: wrap and fold
    logic                 b_vld_reg;
    logic signed [ZW-1:0] b_pz_reg, b_rz_reg, b_pz_next, b_rz_next;
    rot_side_t            b_pside_reg, b_pside_next;
    ang_flags_t           b_rflags_reg, b_rflags_next;

    // sin/cos chains
    logic                 rp_vld [0:N];
    logic signed [XW-1:0] rp_x [0:N];
    logic signed [XW-1:0] rp_y [0:N];
    logic signed [ZW-1:0] rp_z [0:N];
    logic [RSW-1:0]       rp_side [0:N];
    logic                 rr_vld [0:N];
    logic signed [XW-1:0] rr_x [0:N];
    logic signed [XW-1:0] rr_y [0:N];
    logic signed [ZW-1:0] rr_z [0:N];
    logic [AFW-1:0]       rr_side [0:N];

    // stage C: magnitudes
    logic          c_vld_reg;
    logic [QW-1:0] c_sp_reg, c_cp_reg, c_sr_reg, c_cr_reg;
    logic [QW-1:0] c_sp_next, c_cp_next, c_sr_next, c_cr_next;
    quad_t         c_quad_reg;
    rot_side_t     rp_end;
    ang_flags_t    rr_end;

    // stage D: first products
    logic            d_vld_reg;
    logic [QW-1:0]   d_a_reg, d_b_reg, d_bb_reg, d_sp_reg, d_cp_reg;
    logic [2*QW-1:0] d_a_prod, d_bb_prod;
    quad_t           d_quad_reg;

    // stage E: numerator
    logic            e_vld_reg;
    logic [2*QW-1:0] e_t1_prod, e_t2_prod;
    logic [NUMW-1:0] e_num_next;
    v1_side_t        e_side_reg, e_side_next;

    // first vectoring chain
    logic                 v1_vld [0:N];
    logic signed [XW-1:0] v1_x [0:N];
    logic signed [XW-1:0] v1_y [0:N];
    logic signed [ZW-1:0] v1_z [0:N];
    logic [V1W-1:0]       v1_side [0:N];

    // stage F: direction angle and magnitude
    logic                 f_vld_reg;
    logic signed [ZW-1:0] f_ang_reg, f_ang_next;
    logic [DW-1:0]        f_den_reg, f_den_next;
    logic [NUMW-1:0]      f_num_reg;
    quad_t                f_quad_reg;
    v1_side_t             v1_end;
    logic [XW-2:0]        f_xc;
    logic [XW-2+28:0]     f_dmul;

    // stage G: divider setup
    logic          g_vld_reg;
    logic [DW-1:0] g_den_reg;
    logic [REMW-1:0] g_rem_reg;
    div_side_t     g_side_reg, g_side_next;

    // divider chain
    logic            dv_vld [0:DIV_STEPS];
    logic [REMW-1:0] dv_rem [0:DIV_STEPS];
    logic [DW-1:0]   dv_den [0:DIV_STEPS];
    logic [QTW-1:0]  dv_q [0:DIV_STEPS];
    logic [DVW-1:0]  dv_side [0:DIV_STEPS];

    // stage H: clamp z
    logic           h_vld_reg;
    logic [QTW-1:0] h_zq_reg, h_zq_next;
    div_side_t      h_side_reg, dv_end;

    // stage I: radicand
    logic             i_vld_reg;
    logic [SQW-1:0]   i_v_reg;
    logic [2*QTW-1:0] i_zz;
    sq_side_t         i_side_reg, i_side_next;

    // square root chain
    logic            sq_vld [0:SQ_STEPS];
    logic [SQW-1:0]  sq_v [0:SQ_STEPS];
    logic [SQW-1:0]  sq_r [0:SQ_STEPS];
    logic [SQSW-1:0] sq_side [0:SQ_STEPS];
    sq_side_t        sq_end;
    v2_side_t        v2_start;

    // second vectoring chain
    logic                 v2_vld [0:N];
    logic signed [XW-1:0] v2_x [0:N];
    logic signed [XW-1:0] v2_y [0:N];
    logic signed [ZW-1:0] v2_z [0:N];
    logic [V2W-1:0]       v2_side [0:N];
    v2_side_t             v2_end;

    // output register
    logic                 out_valid_reg;
    logic signed [15:0]   dir_reg, dir_next;
    logic [13:0]          tilt_reg, tilt_next, dir_mag;
    logic signed [ZW-1:0] tilt_ang;
    logic                 deg_reg;

    assign adv      = !out_valid_reg || !out_stall;
    assign in_stall = !adv;

    // ---------------- stage A
    always_comb
    begin
        a_quad_next.p_le0 = (pitch_deg <= 15'sd0);
        a_quad_next.r_le0 = (roll_deg <= 15'sd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_vld_reg <= 1'b0;
        else if (adv)
            a_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_pmag_reg <= deg_to_ang(pitch_deg);
            a_rmag_reg <= deg_to_ang(roll_deg);
            a_pneg_reg <= pitch_deg[14];
            a_rneg_reg <= roll_deg[14];
            a_quad_reg <= a_quad_next;
        end
    end

    // ---------------- stage B
    always_comb
    begin
        b_pz_next                = fold_ang(a_pmag_reg, a_pneg_reg);
        b_rz_next                = fold_ang(a_rmag_reg, a_rneg_reg);
        b_pside_next.quad        = a_quad_reg;
        b_pside_next.flags.zero  = (b_pz_next == '0);
        b_pside_next.flags.quart = (b_pz_next == QUARTER) || (b_pz_next == -QUARTER);
        b_rflags_next.zero       = (b_rz_next == '0);
        b_rflags_next.quart      = (b_rz_next == QUARTER) || (b_rz_next == -QUARTER);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_vld_reg <= 1'b0;
        else if (adv)
            b_vld_reg <= a_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_pz_reg     <= b_pz_next;
            b_rz_reg     <= b_rz_next;
            b_pside_reg  <= b_pside_next;
            b_rflags_reg <= b_rflags_next;
        end
    end

    // ---------------- sin/cos chains
    assign rp_vld[0]  = b_vld_reg;
    assign rp_x[0]    = GAIN;
    assign rp_y[0]    = '0;
    assign rp_z[0]    = b_pz_reg;
    assign rp_side[0] = b_pside_reg;
    assign rr_vld[0]  = b_vld_reg;
    assign rr_x[0]    = GAIN;
    assign rr_y[0]    = '0;
    assign rr_z[0]    = b_rz_reg;
    assign rr_side[0] = b_rflags_reg;

    for (genvar k = 0; k < N; k++)
    begin : g_rot
        tdfe_cordic_cell #(.VECTOR(1'b0), .STAGE(k), .SIDE_W(RSW)) u_p (
            .clk(clk), .rst_n(rst_n), .en(adv), .vld_in(rp_vld[k]),
            .x_in(rp_x[k]), .y_in(rp_y[k]), .z_in(rp_z[k]), .side_in(rp_side[k]),
            .vld_out(rp_vld[k+1]), .x_out(rp_x[k+1]), .y_out(rp_y[k+1]),
            .z_out(rp_z[k+1]), .side_out(rp_side[k+1])
        );
        tdfe_cordic_cell #(.VECTOR(1'b0), .STAGE(k), .SIDE_W(AFW)) u_r (
            .clk(clk), .rst_n(rst_n), .en(adv), .vld_in(rr_vld[k]),
            .x_in(rr_x[k]), .y_in(rr_y[k]), .z_in(rr_z[k]), .side_in(rr_side[k]),
            .vld_out(rr_vld[k+1]), .x_out(rr_x[k+1]), .y_out(rr_y[k+1]),
            .z_out(rr_z[k+1]), .side_out(rr_side[k+1])
        );
    end

    // ---------------- stage C
    always_comb
    begin
        rp_end = rot_side_t'(rp_side[N]);
        rr_end = ang_flags_t'(rr_side[N]);
        if (rp_end.flags.zero)
        begin
            c_sp_next = '0;
            c_cp_next = QONE;
        end
        else if (rp_end.flags.quart)
        begin
            c_sp_next = QONE;
            c_cp_next = '0;
        end
        else
        begin
            c_sp_next = mag_of(rp_y[N]);
            c_cp_next = mag_of(rp_x[N]);
        end
        if (rr_end.zero)
        begin
            c_sr_next = '0;
            c_cr_next = QONE;
        end
        else if (rr_end.quart)
        begin
            c_sr_next = QONE;
            c_cr_next = '0;
        end
        else
        begin
            c_sr_next = mag_of(rr_y[N]);
            c_cr_next = mag_of(rr_x[N]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_vld_reg <= 1'b0;
        else if (adv)
            c_vld_reg <= rp_vld[N] & rr_vld[N];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_sp_reg   <= c_sp_next;
            c_cp_reg   <= c_cp_next;
            c_sr_reg   <= c_sr_next;
            c_cr_reg   <= c_cr_next;
            c_quad_reg <= rp_end.quad;
        end
    end

    // ---------------- stage D
    assign d_a_prod  = c_sp_reg * c_cr_reg;
    assign d_bb_prod = c_sr_reg * c_sr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d_vld_reg <= 1'b0;
        else if (adv)
            d_vld_reg <= c_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_a_reg    <= d_a_prod[QW+27:28];
            d_bb_reg   <= d_bb_prod[QW+27:28];
            d_b_reg    <= c_sr_reg;
            d_sp_reg   <= c_sp_reg;
            d_cp_reg   <= c_cp_reg;
            d_quad_reg <= c_quad_reg;
        end
    end

    // ---------------- stage E
    always_comb
    begin
        e_t1_prod        = d_bb_reg * d_cp_reg;
        e_t2_prod        = d_a_reg * d_sp_reg;
        e_num_next       = e_t1_prod[NUMW+27:28] + e_t2_prod[NUMW+27:28];
        e_side_next.quad = d_quad_reg;
        e_side_next.a    = d_a_reg;
        e_side_next.b    = d_b_reg;
        e_side_next.num  = e_num_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            e_vld_reg <= 1'b0;
        else if (adv)
            e_vld_reg <= d_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            e_side_reg <= e_side_next;
    end

    // ---------------- first vectoring chain: atan2(A, B)
    assign v1_vld[0]  = e_vld_reg;
    assign v1_x[0]    = XW'(e_side_reg.b);
    assign v1_y[0]    = XW'(e_side_reg.a);
    assign v1_z[0]    = '0;
    assign v1_side[0] = e_side_reg;

    for (genvar k = 0; k < N; k++)
    begin : g_vec1
        tdfe_cordic_cell #(.VECTOR(1'b1), .STAGE(k), .SIDE_W(V1W)) u_cell (
            .clk(clk), .rst_n(rst_n), .en(adv), .vld_in(v1_vld[k]),
            .x_in(v1_x[k]), .y_in(v1_y[k]), .z_in(v1_z[k]), .side_in(v1_side[k]),
            .vld_out(v1_vld[k+1]), .x_out(v1_x[k+1]), .y_out(v1_y[k+1]),
            .z_out(v1_z[k+1]), .side_out(v1_side[k+1])
        );
    end

    // ---------------- stage F
    always_comb
    begin
        v1_end = v1_side_t'(v1_side[N]);
        f_xc   = v1_x[N][XW-1] ? '0 : v1_x[N][XW-2:0];
        f_dmul = f_xc * GAIN_U;
        if (v1_end.a == '0)
        begin
            f_ang_next = '0;
            f_den_next = v1_end.b;
        end
        else if (v1_end.b == '0)
        begin
            f_ang_next = QUARTER;
            f_den_next = v1_end.a;
        end
        else
        begin
            f_ang_next = v1_z[N];
            f_den_next = f_dmul[DW+27:28];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f_vld_reg <= 1'b0;
        else if (adv)
            f_vld_reg <= v1_vld[N];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f_ang_reg  <= f_ang_next;
            f_den_reg  <= f_den_next;
            f_num_reg  <= v1_end.num;
            f_quad_reg <= v1_end.quad;
        end
    end

    // ---------------- stage G
    always_comb
    begin
        g_side_next.quad = f_quad_reg;
        g_side_next.deg  = (f_den_reg == '0);
        g_side_next.ovf  = {1'b0, f_num_reg} >= {f_den_reg, 1'b0};
        g_side_next.ang  = f_ang_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            g_vld_reg <= 1'b0;
        else if (adv)
            g_vld_reg <= f_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            g_rem_reg  <= REMW'(f_num_reg);
            g_den_reg  <= f_den_reg;
            g_side_reg <= g_side_next;
        end
    end

    // ---------------- divider chain: z = (num << 28) / D
    assign dv_vld[0]  = g_vld_reg;
    assign dv_rem[0]  = g_rem_reg;
    assign dv_den[0]  = g_den_reg;
    assign dv_q[0]    = '0;
    assign dv_side[0] = g_side_reg;

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_div
        tdfe_div_cell #(.SIDE_W(DVW)) u_cell (
            .clk(clk), .rst_n(rst_n), .en(adv), .vld_in(dv_vld[k]),
            .rem_in(dv_rem[k]), .den_in(dv_den[k]), .q_in(dv_q[k]),
            .side_in(dv_side[k]), .vld_out(dv_vld[k+1]), .rem_out(dv_rem[k+1]),
            .den_out(dv_den[k+1]), .q_out(dv_q[k+1]), .side_out(dv_side[k+1])
        );
    end

    // ---------------- stage H
    always_comb
    begin
        dv_end = div_side_t'(dv_side[DIV_STEPS]);
        if (dv_end.ovf || (dv_q[DIV_STEPS] > QONE_Z))
            h_zq_next = QONE_Z;
        else
            h_zq_next = dv_q[DIV_STEPS];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            h_vld_reg <= 1'b0;
        else if (adv)
            h_vld_reg <= dv_vld[DIV_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            h_zq_reg   <= h_zq_next;
            h_side_reg <= dv_end;
        end
    end

    // ---------------- stage I
    always_comb
    begin
        i_zz             = h_zq_reg * h_zq_reg;
        i_side_next.quad = h_side_reg.quad;
        i_side_next.deg  = h_side_reg.deg;
        i_side_next.ang  = h_side_reg.ang;
        i_side_next.zq   = h_zq_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            i_vld_reg <= 1'b0;
        else if (adv)
            i_vld_reg <= h_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            i_v_reg    <= SQ_TOP - SQW'(i_zz);
            i_side_reg <= i_side_next;
        end
    end

    // ---------------- square root chain
    assign sq_vld[0]  = i_vld_reg;
    assign sq_v[0]    = i_v_reg;
    assign sq_r[0]    = '0;
    assign sq_side[0] = i_side_reg;

    for (genvar k = 0; k < SQ_STEPS; k++)
    begin : g_sqrt
        tdfe_sqrt_cell #(.STEP(k), .SIDE_W(SQSW)) u_cell (
            .clk(clk), .rst_n(rst_n), .en(adv), .vld_in(sq_vld[k]),
            .v_in(sq_v[k]), .r_in(sq_r[k]), .side_in(sq_side[k]),
            .vld_out(sq_vld[k+1]), .v_out(sq_v[k+1]), .r_out(sq_r[k+1]),
            .side_out(sq_side[k+1])
        );
    end

    // ---------------- second vectoring chain: atan2(z, w)
    always_comb
    begin
        sq_end        = sq_side_t'(sq_side[SQ_STEPS]);
        v2_start.quad = sq_end.quad;
        v2_start.deg  = sq_end.deg;
        v2_start.ang  = sq_end.ang;
        v2_start.y0   = (sq_end.zq == '0);
        v2_start.x0   = (sq_r[SQ_STEPS] == '0);
    end

    assign v2_vld[0]  = sq_vld[SQ_STEPS];
    assign v2_x[0]    = XW'(sq_r[SQ_STEPS][QTW-1:0]);
    assign v2_y[0]    = XW'(sq_end.zq);
    assign v2_z[0]    = '0;
    assign v2_side[0] = v2_start;

    for (genvar k = 0; k < N; k++)
    begin : g_vec2
        tdfe_cordic_cell #(.VECTOR(1'b1), .STAGE(k), .SIDE_W(V2W)) u_cell (
            .clk(clk), .rst_n(rst_n), .en(adv), .vld_in(v2_vld[k]),
            .x_in(v2_x[k]), .y_in(v2_y[k]), .z_in(v2_z[k]), .side_in(v2_side[k]),
            .vld_out(v2_vld[k+1]), .x_out(v2_x[k+1]), .y_out(v2_y[k+1]),
            .z_out(v2_z[k+1]), .side_out(v2_side[k+1])
        );
    end

    // ---------------- output register
    always_comb
    begin
        v2_end = v2_side_t'(v2_side[N]);
        if (v2_end.y0)
            tilt_ang = '0;
        else if (v2_end.x0)
            tilt_ang = QUARTER;
        else
            tilt_ang = v2_z[N];
        dir_mag = to_out(v2_end.ang);
        if (v2_end.quad.p_le0 && v2_end.quad.r_le0)
            dir_next = signed'({2'b00, dir_mag});
        else if (v2_end.quad.p_le0)
            dir_next = 16'sd16384 - signed'({2'b00, dir_mag});
        else if (!v2_end.quad.r_le0)
            dir_next = signed'({2'b00, dir_mag}) - 16'sd16384;
        else
            dir_next = -signed'({2'b00, dir_mag});
        tilt_next = to_out(tilt_ang);
        if (v2_end.deg)
        begin
            dir_next  = '0;
            tilt_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= v2_vld[N];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dir_reg  <= dir_next;
            tilt_reg <= tilt_next;
            deg_reg  <= v2_end.deg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign slope_direction = dir_reg;
    assign slope_tilt      = tilt_reg;
    assign degenerate      = deg_reg;

endmodule
`default_nettype wire
